/* sv/aes128_pkg.sv */
// Shared types, constants and S-box for the AES-128 round key expander.
`timescale 1ns / 1ps
`default_nettype none
package aes128_pkg;

  localparam int unsigned ROUNDS = 10;
  localparam int unsigned RND_W  = 4;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
  } key_t;

  typedef struct packed {
    logic              last;
    logic [RND_W-1:0]  round_number;
    logic [63:0]       round_key_high;
    logic [63:0]       round_key_low;
  } rkey_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tbl[a];
  endfunction

  // Round constant for round r (1..10).
  function automatic logic [7:0] rcon(input logic [RND_W-1:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* sv/aes128_key_fifo.sv */
// Two-entry key queue between the input side and the schedule engine.
`timescale 1ns / 1ps
`default_nettype none
module aes128_key_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire aes128_pkg::key_t  wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output aes128_pkg::key_t       rd_data
);
  import aes128_pkg::*;

  key_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wptr <= ~wptr;
      if (do_rd) rptr <= ~rptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule
`default_nettype wire

/* sv/aes128_sched.sv */
// Schedule engine: one round key per unstalled cycle into a registered output stage.
`timescale 1ns / 1ps
`default_nettype none
module aes128_sched (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              key_valid,
  output logic                   key_ready,
  input  wire aes128_pkg::key_t  key,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output aes128_pkg::rkey_t      out_data
);
  import aes128_pkg::*;

  logic [31:0]      w0, w1, w2, w3;
  logic [RND_W-1:0] rnd;
  logic             busy;
  logic             slot_free;
  logic [31:0]      s, t, n0, n1, n2, n3;

  assign slot_free = !out_valid || out_ready;
  // Take a new key when idle, or in the cycle that round 10 leaves.
  assign key_ready = slot_free && (!busy || rnd == RND_W'(ROUNDS));

  assign s  = {sbox(w3[31:24]), sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0])};
  assign t  = {s[7:0], s[31:8]} ^ {24'd0, rcon(rnd + 4'd1)};
  assign n0 = w0 ^ t;
  assign n1 = w1 ^ n0;
  assign n2 = w2 ^ n1;
  assign n3 = w3 ^ n2;

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (key_valid && key_ready) begin
        {w1, w0} <= key.key_low;
        {w3, w2} <= key.key_high;
        out_data <= '{last: 1'b0, round_number: '0,
                      round_key_high: key.key_high, round_key_low: key.key_low};
      end else if (busy) begin
        w0 <= n0; w1 <= n1; w2 <= n2; w3 <= n3;
        out_data <= '{last: (rnd + 4'd1) == RND_W'(ROUNDS),
                      round_number: rnd + 4'd1,
                      round_key_high: {n3, n2}, round_key_low: {n1, n0}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else if (slot_free) begin
      if (key_valid && key_ready) begin
        busy      <= 1'b1;
        rnd       <= '0;
        out_valid <= 1'b1;
      end else if (busy && rnd != RND_W'(ROUNDS)) begin
        rnd       <= rnd + 4'd1;
        out_valid <= 1'b1;
      end else begin
        busy      <= 1'b0;
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* sv/aes128_round_key_expander_core.sv */
// Top level of the AES-128 round key expander.
//
//  channel | dir | handshake           | contents
//  s_axis  | in  | tvalid/tready       | tdata[127:0] = key_low, key_high
//  m_axis  | out | tvalid/tready/tlast | tdata[135:0] = round_number(4), key lo, key hi
//
// Each key request yields 11 round keys, one per cycle while the output is not stalled,
// as the schedule engine computes one round per cycle.
// A two-entry queue buffers keys, so the next key is taken while results drain.
// Output stalls hold the engine; reset (rst, synchronous) empties the queue and engine.
`timescale 1ns / 1ps
`default_nettype none
module aes128_round_key_expander_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [127:0]  s_axis_tdata,  // key_low[63:0], key_high[127:64]
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [135:0]       m_axis_tdata,  // round_number[3:0], key_low[67:4],
                                            // key_high[131:68], zero pad
  output logic               m_axis_tlast
);
  import aes128_pkg::*;

  key_t  in_key;
  key_t  q_key;
  logic  q_valid;
  logic  q_ready;
  rkey_t rk;

  assign in_key = '{key_high: s_axis_tdata[127:64], key_low: s_axis_tdata[63:0]};

  // Front: queue incoming key requests.
  aes128_key_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (s_axis_tvalid),
    .wr_ready (s_axis_tready),
    .wr_data  (in_key),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_key)
  );

  // Back: expand keys round by round.
  aes128_sched u_sched (
    .clk       (clk),
    .rst       (rst),
    .key_valid (q_valid),
    .key_ready (q_ready),
    .key       (q_key),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (rk)
  );

  assign m_axis_tdata = {4'd0, rk.round_key_high, rk.round_key_low, rk.round_number};
  assign m_axis_tlast = rk.last;
endmodule
`default_nettype wire
